// ===== design/naf_rcd_pkg.sv =====
`timescale 1ns / 1ps

package naf_rcd_pkg;

	localparam int LIMB_W = 64;
	localparam int POS_W  = 6;
	// limb position, wide enough for the largest supported scalar (64 limbs)
	localparam int IDX_W  = 6;
	localparam int CNT_W  = 11;
	// digit count before it is cut to the port width: (64 limbs) * 64 + 1 fits
	localparam int CALC_W = 13;

	typedef struct packed {
		logic [LIMB_W-1:0] nz;
		logic [LIMB_W-1:0] neg;
		logic              last;
		logic              top;
		logic [IDX_W-1:0]  idx;
	} naf_rcd_dig_t;

	// position of the highest set bit, halving the search window each step
	function automatic logic [POS_W-1:0] msb_pos(input logic [LIMB_W-1:0] x);
		logic [LIMB_W-1:0] v;
		logic [POS_W-1:0]  p;
		v = x;
		p = '0;
		for (int k = POS_W - 1; k >= 0; k--) begin
			if ((v >> (1 << k)) != '0) begin
				p[k] = 1'b1;
				v    = v >> (1 << k);
			end
		end
		return p;
	endfunction

endpackage

// ===== design/naf_rcd_limb.sv =====
`timescale 1ns / 1ps

module naf_rcd_limb #(
	parameter int NUM_LIMBS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [63:0]                 limb,
	input  logic                        final_limb,
	output logic                        dig_valid_s1,
	output naf_rcd_pkg::naf_rcd_dig_t   dig_s1,
	input  logic                        dig_ready
);
	import naf_rcd_pkg::*;

	localparam int IW = (NUM_LIMBS > 1) ? $clog2(NUM_LIMBS) : 1;

	logic [LIMB_W-1:0] held_q;
	logic              held_v_q;
	logic              pend_q;
	logic              carry_q;
	logic [IW-1:0]     idx_q;

	logic              s1_en;
	logic              acc;
	logic              fire;
	logic              nb;
	logic [LIMB_W-1:0] half;
	logic [LIMB_W:0]   sum;
	logic [LIMB_W-1:0] s;

	assign s1_en    = !dig_valid_s1 || dig_ready;
	// a pending final limb owns the adder until its digits are registered
	assign in_ready = !pend_q && s1_en;
	assign acc      = in_valid && in_ready;
	assign fire     = s1_en && (pend_q || (acc && held_v_q));

	// the limb above the final one is taken as zero
	assign nb   = pend_q ? 1'b0 : limb[0];
	assign half = {nb, held_q[LIMB_W-1:1]};
	assign sum  = {1'b0, held_q} + {1'b0, half} + (LIMB_W+1)'(carry_q);
	assign s    = sum[LIMB_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_v_q     <= 1'b0;
			pend_q       <= 1'b0;
			carry_q      <= 1'b0;
			idx_q        <= '0;
			dig_valid_s1 <= 1'b0;
		end else begin
			if (s1_en) begin
				dig_valid_s1 <= fire;
			end
			if (fire) begin
				if (pend_q) begin
					held_v_q <= 1'b0;
					pend_q   <= 1'b0;
					carry_q  <= 1'b0;
					idx_q    <= '0;
				end else begin
					carry_q <= sum[LIMB_W];
					if (idx_q != IW'(NUM_LIMBS - 1)) begin
						idx_q <= idx_q + 1'b1;
					end
				end
			end
			if (acc) begin
				held_v_q <= 1'b1;
				pend_q   <= final_limb;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			held_q <= limb;
		end
		if (fire) begin
			dig_s1.nz   <= s ^ half;
			dig_s1.neg  <= half & ~s;
			dig_s1.last <= pend_q;
			dig_s1.top  <= pend_q && sum[LIMB_W];
			dig_s1.idx  <= IDX_W'(idx_q);
		end
	end

endmodule

// ===== design/naf_rcd_count.sv =====
`timescale 1ns / 1ps

module naf_rcd_count (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        dig_valid_s1,
	input  naf_rcd_pkg::naf_rcd_dig_t   dig_s1,
	output logic                        dig_ready,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [63:0]                 nonzero_mask,
	output logic [63:0]                 negative_mask,
	output logic                        top_digit,
	output logic [10:0]                 digit_count,
	output logic                        end_of_scalar
);
	import naf_rcd_pkg::*;

	logic [CALC_W-1:0] highest_q;
	logic [CALC_W-1:0] cnt_nz;
	logic [CALC_W-1:0] cnt_top;
	logic [CALC_W-1:0] hd_new;
	logic              s2_en;
	logic              mv;

	assign s2_en     = !out_valid || out_ready;
	assign dig_ready = s2_en;
	assign mv        = dig_valid_s1 && s2_en;

	// idx * 64 + pos + 1, and (idx + 1) * 64 + 1 for the carry digit
	assign cnt_nz  = CALC_W'({dig_s1.idx, msb_pos(dig_s1.nz)}) + CALC_W'(1);
	assign cnt_top = CALC_W'({dig_s1.idx, {POS_W{1'b0}}}) + CALC_W'(65);

	always_comb begin
		if (dig_s1.top) begin
			hd_new = cnt_top;
		end else if (dig_s1.nz != '0) begin
			hd_new = cnt_nz;
		end else begin
			hd_new = highest_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			highest_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (s2_en) begin
				out_valid <= dig_valid_s1;
			end
			if (mv) begin
				highest_q <= dig_s1.last ? '0 : hd_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mv) begin
			nonzero_mask  <= dig_s1.nz;
			negative_mask <= dig_s1.neg;
			top_digit     <= dig_s1.top;
			digit_count   <= dig_s1.last ? CNT_W'(hd_new) : '0;
			end_of_scalar <= dig_s1.last;
		end
	end

endmodule

// ===== design/naf_scalar_recoder_core.sv =====
`timescale 1ns / 1ps
// Order: a limb's result enters the digit register once the request carrying the next limb
// is accepted, the final limb's once it has held the adder; the output register follows.
// Throughput: one limb request per cycle while the output is not stalled; after a scalar's
// final limb no request is taken while that limb holds the shared 64-bit adder.
// Reset: arst_n clears the held-limb flags, carry, limb index, digit count and valids.

module naf_scalar_recoder_core #(
	parameter int NUM_LIMBS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] limb,
	input  logic        final_limb,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] nonzero_mask,
	output logic [63:0] negative_mask,
	output logic        top_digit,
	output logic [10:0] digit_count,
	output logic        end_of_scalar
);
	import naf_rcd_pkg::*;

	// Digit stage: each request's limb is held until the next one arrives, since
	// the top digit of a limb depends on the low bit of its successor. The held
	// limb is recoded as held + (held >> 1) plus the running carry; the digit masks
	// fall out of an XOR and an AND-NOT against the shifted copy.
	logic         dig_valid_s1;
	naf_rcd_dig_t dig_s1;
	logic         dig_ready;

	naf_rcd_limb #(
		.NUM_LIMBS (NUM_LIMBS)
	) u_limb (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.limb         (limb),
		.final_limb   (final_limb),
		.dig_valid_s1 (dig_valid_s1),
		.dig_s1       (dig_s1),
		.dig_ready    (dig_ready)
	);

	// Count stage: find the highest nonzero digit of each limb, track the running
	// digit count, and drive the output register. A stalled output does not stall
	// the digit stage until its own register is also full.
	naf_rcd_count u_count (
		.clk           (clk),
		.arst_n        (arst_n),
		.dig_valid_s1  (dig_valid_s1),
		.dig_s1        (dig_s1),
		.dig_ready     (dig_ready),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.nonzero_mask  (nonzero_mask),
		.negative_mask (negative_mask),
		.top_digit     (top_digit),
		.digit_count   (digit_count),
		.end_of_scalar (end_of_scalar)
	);

`ifndef SYNTH
	// the cycle after a final limb is taken, the adder is busy with it
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && final_limb |=> !in_ready)
	else $error("request accepted while final limb pending");

	// count and carry digit are reported on the final result only
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !end_of_scalar |-> digit_count == '0 && top_digit == 1'b0)
	else $error("count or top digit on a non-final result");

	// a set carry digit means the count lands just past a limb boundary
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && top_digit |-> digit_count[5:0] == 6'd1)
	else $error("top digit with misplaced digit count");
`endif

endmodule

// ===== test/naf_scalar_recoder_core_tb.sv =====
`timescale 1ns / 1ps

module naf_scalar_recoder_core_tb;

	import naf_rcd_pkg::*;

	localparam int NUM_LIMBS = 16;

	// One limb's worth of digits as the block reports it
	typedef struct {
		logic [LIMB_W-1:0] nz;
		logic [LIMB_W-1:0] neg;
		logic              top;
		logic [CNT_W-1:0]  count;
		logic              eos;
	} naf_digits_t;

	// Recodes every accepted limb on its own and holds the digit sets still due
	class naf_board;
		naf_digits_t       due[$];
		logic [LIMB_W-1:0] held_limb;
		bit                held_valid;
		bit                carry;
		int unsigned       limb_pos;
		int unsigned       highest;
		int unsigned       scalar_limbs;
		int unsigned       mismatches;
		int unsigned       results_seen;
		int unsigned       scalars_done;
		int unsigned       carry_outs;
		int unsigned       saturated;

		function new();
			mismatches   = 0;
			results_seen = 0;
			scalars_done = 0;
			carry_outs   = 0;
			saturated    = 0;
			restart();
		endfunction

		function void restart();
			held_limb    = '0;
			held_valid   = 0;
			carry        = 0;
			limb_pos     = 0;
			highest      = 0;
			scalar_limbs = 0;
		endfunction

		// Append one digit set behind those already due
		function void add_due(naf_digits_t d);
			due = {due, d};
		endfunction

		function int top_one(logic [LIMB_W-1:0] x);
			for (int i = LIMB_W - 1; i >= 0; i--) begin
				if (x[i])
					return i;
			end
			return -1;
		endfunction

		// Digits of one limb: bit i of (k + k/2) against bit i of k/2
		function naf_digits_t recode(logic [LIMB_W-1:0] cur, bit next_bit);
			logic [LIMB_W-1:0] half;
			logic [LIMB_W:0]   sum;
			naf_digits_t       d;
			half    = {next_bit, cur[LIMB_W-1:1]};
			sum     = {1'b0, cur} + {1'b0, half} + {{LIMB_W{1'b0}}, carry};
			carry   = sum[LIMB_W];
			d.nz    = sum[LIMB_W-1:0] ^ half;
			d.neg   = half & ~sum[LIMB_W-1:0];
			d.top   = 0;
			d.count = '0;
			d.eos   = 0;
			if (d.nz != '0)
				highest = limb_pos * 64 + top_one(d.nz) + 1;
			// the position sticks at the last slot once the scalar runs long
			if (limb_pos < NUM_LIMBS - 1)
				limb_pos++;
			return d;
		endfunction

		function void note_request(logic [LIMB_W-1:0] l, bit f);
			naf_digits_t d;
			int unsigned final_pos;
			scalar_limbs++;
			if (held_valid)
				add_due(recode(held_limb, l[0]));
			if (!f) begin
				held_limb  = l;
				held_valid = 1;
				return;
			end
			final_pos = limb_pos;
			d = recode(l, 1'b0);
			if (carry) begin
				highest = (final_pos + 1) * 64 + 1;
				carry_outs++;
			end
			if (scalar_limbs > NUM_LIMBS)
				saturated++;
			d.top   = carry;
			d.count = highest[CNT_W-1:0];
			d.eos   = 1;
			add_due(d);
			scalars_done++;
			restart();
		endfunction

		function void flag(string what, logic [LIMB_W-1:0] e, logic [LIMB_W-1:0] a);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch at result %0d: %s expected %h got %h",
					results_seen, what, e, a);
		endfunction

		function void check_result(naf_digits_t act);
			naf_digits_t e;
			results_seen++;
			if (due.size() == 0) begin
				flag("unexpected result, nonzero_mask", '0, act.nz);
				return;
			end
			e = due.pop_front();
			if (act.nz !== e.nz)
				flag("nonzero_mask", e.nz, act.nz);
			if (act.neg !== e.neg)
				flag("negative_mask", e.neg, act.neg);
			if (act.top !== e.top)
				flag("top_digit", 64'(e.top), 64'(act.top));
			if (act.count !== e.count)
				flag("digit_count", 64'(e.count), 64'(act.count));
			if (act.eos !== e.eos)
				flag("end_of_scalar", 64'(e.eos), 64'(act.eos));
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [LIMB_W-1:0] limb = '0;
	logic              final_limb = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [LIMB_W-1:0] nonzero_mask;
	logic [LIMB_W-1:0] negative_mask;
	logic              top_digit;
	logic [CNT_W-1:0]  digit_count;
	logic              end_of_scalar;

	naf_board    board;
	bit          idle_on = 0;
	int unsigned limbs_sent = 0;

	always #5 clk = ~clk;

	naf_scalar_recoder_core #(
		.NUM_LIMBS(NUM_LIMBS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.limb(limb),
		.final_limb(final_limb),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.nonzero_mask(nonzero_mask),
		.negative_mask(negative_mask),
		.top_digit(top_digit),
		.digit_count(digit_count),
		.end_of_scalar(end_of_scalar)
	);

	// mostly no gap, some short ones, now and then a long one
	function int gap_len();
		int r;
		r = $urandom_range(99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	function logic [LIMB_W-1:0] pick_limb();
		logic [LIMB_W-1:0] a;
		logic [LIMB_W-1:0] b;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return {LIMB_W/2{2'b01}};
			3: return {LIMB_W/2{2'b10}};
			4: return {{(LIMB_W-1){1'b0}}, 1'b1} << $urandom_range(LIMB_W - 1);
			5: return a & b & {$urandom, $urandom};
			6: return a | b;
			7: return ~({{(LIMB_W-1){1'b0}}, 1'b1} << $urandom_range(LIMB_W - 1));
			default: return a;
		endcase
	endfunction

	// Present one limb and hold it until the block takes the request
	task automatic send_limb(input logic [LIMB_W-1:0] l, input bit f);
		int g;
		if (idle_on) begin
			g = gap_len();
			if (g > 0) begin
				in_valid <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
		in_valid   <= 1'b1;
		limb       <= l;
		final_limb <= f;
		do @(posedge clk); while (!in_ready);
		board.note_request(l, f);
		limbs_sent++;
	endtask

	// Drop valid and hold off until every digit set already due has come back
	task automatic drain();
		in_valid <= 1'b0;
		while (board.due.size() != 0)
			@(posedge clk);
	endtask

	// Result side: check on every accepted result, stall at random while idling is on
	initial begin
		naf_digits_t r;
		int          stall;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				r.nz    = nonzero_mask;
				r.neg   = negative_mask;
				r.top   = top_digit;
				r.count = digit_count;
				r.eos   = end_of_scalar;
				board.check_result(r);
			end
			if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else if (idle_on) begin
				stall = gap_len();
				if (stall > 0) begin
					stall--;
					out_ready <= 1'b0;
				end else begin
					out_ready <= 1'b1;
				end
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		int len;
		int nscalars;
		bit ones_only;
		board = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: single-limb extremes, carry out of the top, carries across limbs
		send_limb('0, 1);
		send_limb('1, 1);
		send_limb(64'h1, 1);
		send_limb(64'h8000_0000_0000_0000, 1);
		send_limb(64'h7FFF_FFFF_FFFF_FFFF, 1);
		send_limb(64'h5555_5555_5555_5555, 1);
		send_limb('1, 0);
		send_limb('1, 1);
		send_limb(64'hAAAA_AAAA_AAAA_AAAA, 0);
		send_limb(64'h5555_5555_5555_5555, 1);
		send_limb(64'h8000_0000_0000_0000, 0);
		send_limb('0, 0);
		send_limb(64'h1, 1);
		send_limb('0, 0);
		send_limb('0, 1);
		send_limb(64'hC000_0000_0000_0000, 0);
		send_limb(64'h1, 1);
		drain();

		// Random scalars, mostly short, a few past the limb limit
		nscalars = 0;
		idle_on  = 1;
		while (limbs_sent < 17 + 450) begin
			if (nscalars % 12 == 0)
				idle_on = ($urandom_range(3) != 0);
			if (nscalars % 50 == 25)
				drain();
			ones_only = 0;
			if (nscalars % 25 == 7) begin
				len       = $urandom_range(NUM_LIMBS + 4, NUM_LIMBS - 2);
				ones_only = $urandom_range(1);
			end else if ($urandom_range(9) < 7) begin
				len = $urandom_range(3, 1);
			end else begin
				len = $urandom_range(8, 4);
			end
			for (int i = 0; i < len; i++)
				send_limb(ones_only ? '1 : pick_limb(), i == len - 1);
			nscalars++;
		end

		in_valid <= 1'b0;
		while (board.due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("checked %0d results from %0d limbs in %0d scalars",
			board.results_seen, limbs_sent, board.scalars_done);
		$display("%0d scalars carried past the top limb, %0d ran beyond %0d limbs, %0d mismatches",
			board.carry_outs, board.saturated, NUM_LIMBS, board.mismatches);
		if (board.mismatches == 0 && board.due.size() == 0) begin
			$display("naf_scalar_recoder_core regression: pass");
		end else begin
			$display("naf_scalar_recoder_core regression: fail");
		end
		$finish;
	end

	// Hard stop well beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("timeout waiting for the recoder");
		$display("naf_scalar_recoder_core regression: fail");
		$finish;
	end

endmodule

// ===== naf_scalar_recoder_core.f =====
design/naf_rcd_pkg.sv
design/naf_rcd_limb.sv
design/naf_rcd_count.sv
design/naf_scalar_recoder_core.sv
test/naf_scalar_recoder_core_tb.sv
